/* rtl/core/icqp_pkg.sv */
// Shared types, codes and constants of the I2C commanded quad PWM block.
package icqp_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int COUNTER_BITS_DEF = 16;
	localparam int MAX_CH           = 4;
	localparam int NUM_TIMERS       = 2;
	localparam int CLK_W            = 27;
	localparam int PERIOD_W         = 16;
	localparam int VALUE_W          = 16;
	localparam int PROD_W           = 32;
	localparam int PSC_W            = 16;

	localparam logic [CLK_W-1:0]    CORE_CLOCK_RST = CLK_W'(48000000);
	localparam logic [PERIOD_W-1:0] PERIOD_RST     = PERIOD_W'(1000);

	localparam logic [3:0] MODE_FREQ_CODE = 4'b0101;
	localparam logic [3:0] MODE_DUTY_CODE = 4'b1010;

	// register select (word address bit 2)
	localparam logic REG_CORE_CLOCK = 1'b0;
	localparam logic REG_PERIOD     = 1'b1;

	typedef enum logic [1:0] {
		ACT_BYTE = 2'd0,
		ACT_STOP = 2'd1,
		ACT_TICK = 2'd2,
		ACT_IDLE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		FM_NONE = 2'd0,
		FM_FREQ = 2'd1,
		FM_DUTY = 2'd2
	} frame_mode_t;

	typedef enum logic [1:0] {
		FS_NONE    = 2'd0,
		FS_DUTY    = 2'd1,
		FS_FREQ    = 2'd2,
		FS_DISCARD = 2'd3
	} frame_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_APPLY
	} ctrl_state_t;

	typedef struct packed {
		logic step;       // apply the accepted word
		logic mul;        // capture period * value
		logic div_start;  // launch the prescaler division
		logic apply;      // commit the frequency frame
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;   // output register can take a word
		logic need_div;   // offered word is a valid frequency stop
		logic div_done;   // quotient ready
	} dp_stat_t;

endpackage

/* rtl/core/icqp_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module icqp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [icqp_pkg::CLK_W-1:0]  dividend,
	input  logic [icqp_pkg::PROD_W-1:0] divisor,
	output logic                        done,
	output logic [icqp_pkg::CLK_W-1:0]  quotient
);
	import icqp_pkg::*;

	localparam int CNT_W = $clog2(CLK_W + 1);

	logic [PROD_W-1:0] rem_q;
	logic [PROD_W-1:0] div_q;
	logic [CLK_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [PROD_W:0]   rem_sh;
	logic              fits;

	// trial subtract
	assign rem_sh = {rem_q, quo_q[CLK_W-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(CLK_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? PROD_W'(rem_sh - {1'b0, div_q}) : rem_sh[PROD_W-1:0];
			quo_q <= {quo_q[CLK_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/core/icqp_ctrl.sv */
// Sequencer: direct steps for most words, and the multiply/divide path of frequency frames.
module icqp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  icqp_pkg::dp_stat_t stat,
	output icqp_pkg::dp_cmd_t  cmd
);
	import icqp_pkg::*;

	ctrl_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_n;
	end

	// next state and commands
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = stat.out_free;
				if (s_tvalid && stat.out_free) begin
					if (stat.need_div) begin
						cmd.mul = 1'b1;
						state_n = ST_MUL;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.div_start = 1'b1;
				state_n       = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) state_n = ST_APPLY;
			end
			ST_APPLY: begin
				if (stat.out_free) begin
					cmd.apply = 1'b1;
					state_n   = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

/* rtl/core/icqp_dp.sv */
// Datapath: frame parser, compare registers, two timers, prescaler math, output word.
module icqp_dp #(
	parameter int NUM_CHANNELS = icqp_pkg::NUM_CHANNELS_DEF,
	parameter int COUNTER_BITS = icqp_pkg::COUNTER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  icqp_pkg::dp_cmd_t             cmd,
	output icqp_pkg::dp_stat_t            stat,
	input  logic [1:0]                    action,
	input  logic [7:0]                    rx_byte,
	input  logic [icqp_pkg::CLK_W-1:0]    core_clock_hz,
	input  logic [icqp_pkg::PERIOD_W-1:0] period_cfg,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata
);
	import icqp_pkg::*;

	localparam int CB = COUNTER_BITS;

	// parse state
	frame_mode_t          mode_q, mode_n;
	logic [3:0]           chan_q, chan_n;
	logic [1:0]           cnt_q, cnt_n;
	logic [VALUE_W-1:0]   val_q, val_n;
	// channel and timer state
	logic [CB-1:0]        pend_q [MAX_CH];
	logic [CB-1:0]        pend_n [MAX_CH];
	logic [CB-1:0]        act_q  [MAX_CH];
	logic [CB-1:0]        act_n  [MAX_CH];
	logic [CB-1:0]        psc_q  [NUM_TIMERS];
	logic [CB-1:0]        psc_n  [NUM_TIMERS];
	logic [CB-1:0]        ps_q   [NUM_TIMERS];
	logic [CB-1:0]        ps_n   [NUM_TIMERS];
	logic [CB-1:0]        pc_q   [NUM_TIMERS];
	logic [CB-1:0]        pc_n   [NUM_TIMERS];
	// output word
	logic                 ovalid_q;
	logic [3:0]           levels_q, levels_n;
	frame_status_t        fstat_q, fstat_n;
	// arithmetic
	logic [PROD_W-1:0]    prod_q;
	logic [PROD_W-1:0]    divisor;
	logic                 div_done;
	logic [CLK_W-1:0]     quot;
	logic [CLK_W-1:0]     quot_m1;
	logic [PSC_W-1:0]     psc_sat;

	logic [CB-1:0]        period_v;
	logic [CB-1:0]        duty;
	logic [3:0]           nib;
	logic                 frame_ok;
	logic [1:0]           ch_idx;
	logic                 tsel;
	logic                 load_out;

	assign period_v = period_cfg[CB-1:0];
	assign nib      = rx_byte[3:0];
	assign ch_idx   = 2'(chan_q - 4'd1);
	assign tsel     = ch_idx[1];
	assign frame_ok = (mode_q != FM_NONE) && (cnt_q == 2'd2) && (chan_q != 4'd0)
		&& ({28'd0, chan_q} <= 32'(NUM_CHANNELS));
	assign duty     = (val_q[CB-1:0] > period_v) ? period_v : val_q[CB-1:0];

	assign stat.need_div = (action == ACT_STOP) && frame_ok && (mode_q == FM_FREQ)
		&& (val_q != '0);
	assign stat.out_free = !ovalid_q || m_tready;
	assign stat.div_done = div_done;

	// period * value, held for the divider
	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= PROD_W'(period_v) * PROD_W'(val_q);
	end
	assign divisor = (prod_q == '0) ? PROD_W'(1) : prod_q;

	icqp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (core_clock_hz),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quot)
	);

	// prescaler = quotient - 1, floored at 0, saturated to 16 bits
	assign quot_m1 = quot - CLK_W'(1);
	assign psc_sat = (quot == '0) ? '0 :
		((quot_m1 > CLK_W'(16'hFFFF)) ? 16'hFFFF : quot_m1[PSC_W-1:0]);

	// next state of one step
	always_comb begin
		mode_n  = mode_q;
		chan_n  = chan_q;
		cnt_n   = cnt_q;
		val_n   = val_q;
		pend_n  = pend_q;
		act_n   = act_q;
		psc_n   = psc_q;
		ps_n    = ps_q;
		pc_n    = pc_q;
		fstat_n = FS_NONE;
		levels_n = '0;

		if (cmd.step) begin
			case (action)
				ACT_BYTE: begin
					if ((nib == MODE_DUTY_CODE || nib == MODE_FREQ_CODE)
							&& mode_q == FM_NONE) begin
						mode_n = (nib == MODE_DUTY_CODE) ? FM_DUTY : FM_FREQ;
						chan_n = rx_byte[7:4];
					end else begin
						if (cnt_q == 2'd0) val_n[7:0]  = val_q[7:0] | rx_byte;
						if (cnt_q == 2'd1) val_n[15:8] = val_q[15:8] | rx_byte;
						if (cnt_q != 2'd3) cnt_n = cnt_q + 2'd1;
					end
				end
				ACT_STOP: begin
					// valid frequency frames take the divider path
					fstat_n = FS_DISCARD;
					if (frame_ok && mode_q == FM_DUTY) begin
						fstat_n = FS_DUTY;
						for (int c = 0; c < MAX_CH; c++)
							if (c < NUM_CHANNELS && ch_idx == 2'(c)) pend_n[c] = duty;
					end
					mode_n = FM_NONE;
					chan_n = '0;
					cnt_n  = '0;
					val_n  = '0;
				end
				ACT_TICK: begin
					for (int t = 0; t < NUM_TIMERS; t++) begin
						if (ps_q[t] >= psc_q[t]) begin
							ps_n[t] = '0;
							if (pc_q[t] >= period_v) begin
								pc_n[t] = '0;
								for (int c = 0; c < MAX_CH; c++)
									if (c < NUM_CHANNELS && (c >> 1) == t) act_n[c] = pend_q[c];
							end else begin
								pc_n[t] = pc_q[t] + 1'b1;
							end
						end else begin
							ps_n[t] = ps_q[t] + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end

		// frequency frame commit
		if (cmd.apply) begin
			fstat_n = FS_FREQ;
			for (int t = 0; t < NUM_TIMERS; t++) begin
				if (tsel == 1'(t)) begin
					psc_n[t] = psc_sat[CB-1:0];
					ps_n[t]  = '0;
					pc_n[t]  = '0;
					for (int c = 0; c < MAX_CH; c++)
						if (c < NUM_CHANNELS && (c >> 1) == t) act_n[c] = pend_q[c];
				end
			end
			mode_n = FM_NONE;
			chan_n = '0;
			cnt_n  = '0;
			val_n  = '0;
		end

		// levels after the step
		for (int c = 0; c < MAX_CH; c++)
			if (c < NUM_CHANNELS) levels_n[c] = pc_n[c >> 1] < act_n[c];
	end

	assign load_out = cmd.step || cmd.apply;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= FM_NONE;
			chan_q   <= '0;
			cnt_q    <= '0;
			val_q    <= '0;
			ovalid_q <= 1'b0;
			for (int c = 0; c < MAX_CH; c++) begin
				pend_q[c] <= '0;
				act_q[c]  <= '0;
			end
			for (int t = 0; t < NUM_TIMERS; t++) begin
				psc_q[t] <= '0;
				ps_q[t]  <= '0;
				pc_q[t]  <= '0;
			end
		end else begin
			mode_q <= mode_n;
			chan_q <= chan_n;
			cnt_q  <= cnt_n;
			val_q  <= val_n;
			pend_q <= pend_n;
			act_q  <= act_n;
			psc_q  <= psc_n;
			ps_q   <= ps_n;
			pc_q   <= pc_n;
			if (load_out)      ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			levels_q <= levels_n;
			fstat_q  <= fstat_n;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {2'b00, fstat_q, levels_q};

endmodule

/* rtl/core/i2c_commanded_quad_pwm.sv */
// Top level: four-channel PWM generator driven by an I2C command word stream.
//
//  channel   direction  handshake                   payload
//  s_*       in         s_tvalid / s_tready         s_tdata rx_byte, s_tuser action
//  m_*       out        m_tvalid / m_tready         m_tdata pwm_levels, frame_status
//  apb       in         psel, penable, pwrite       paddr, pwdata, prdata (pready = 1)
//
// Bytes, ticks and duty or discarded stops are applied as they are accepted; a word is taken
// while the sequencer is idle and the output register is empty or being drained.
// A valid frequency stop runs in order: the accept with the multiply, a divider launch,
// 27 restoring steps of core_clock_hz / (period * value), the done strobe, the apply.
// Reset clears all parse, compare and timer state; config returns to defaults.
// A stalled output holds its word and holds off the input.
module i2c_commanded_quad_pwm #(
	parameter int NUM_CHANNELS = icqp_pkg::NUM_CHANNELS_DEF,
	parameter int COUNTER_BITS = icqp_pkg::COUNTER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [3:0] pwm_levels, [5:4] frame_status, [7:6] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import icqp_pkg::*;

	logic [CLK_W-1:0]    core_clock_q;
	logic [PERIOD_W-1:0] period_q;
	logic                cfg_wr;
	dp_cmd_t             cmd;
	dp_stat_t            stat;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_clock_q <= CORE_CLOCK_RST;
			period_q     <= PERIOD_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_CORE_CLOCK) core_clock_q <= pwdata[CLK_W-1:0];
			if (paddr[2] == REG_PERIOD)     period_q     <= pwdata[PERIOD_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_PERIOD) ? {16'd0, period_q} : {5'd0, core_clock_q};

	icqp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	icqp_dp #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (s_tuser),
		.rx_byte       (s_tdata),
		.core_clock_hz (core_clock_q),
		.period_cfg    (period_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

endmodule

/* tb/icqp_checker.sv */
// Checker for the I2C commanded quad PWM block: it predicts each output word and compares it.
`timescale 1ns / 100ps

module icqp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] action
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [3:0] pwm_levels, [5:4] frame_status, [7:6] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          pending,
	output int          checked,
	output int          duty_frames,
	output int          freq_frames,
	output int          dropped_frames
);
	import icqp_pkg::*;

	// shadow copy of the block's registers and state
	logic [CLK_W-1:0]    clock_hz;
	logic [PERIOD_W-1:0] period;
	frame_mode_t         mode_q;
	logic [3:0]          chan_q;
	logic [1:0]          nbytes_q;
	logic [VALUE_W-1:0]  value_q;
	logic [15:0]         cmp_pend [MAX_CH];
	logic [15:0]         cmp_act  [MAX_CH];
	logic [15:0]         psc      [NUM_TIMERS];
	logic [15:0]         psc_cnt  [NUM_TIMERS];
	logic [15:0]         per_cnt  [NUM_TIMERS];

	logic [7:0] expected_words [$];

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
		errors++;
	endtask

	task automatic load_compares(input int t);
		for (int c = 0; c < MAX_CH; c++)
			if ((c >> 1) == t) cmp_act[c] = cmp_pend[c];
	endtask

	task automatic tick_timer(input int t);
		if (psc_cnt[t] >= psc[t]) begin
			psc_cnt[t] = '0;
			if (per_cnt[t] >= period) begin
				per_cnt[t] = '0;
				load_compares(t);
			end else begin
				per_cnt[t] = per_cnt[t] + 16'd1;
			end
		end else begin
			psc_cnt[t] = psc_cnt[t] + 16'd1;
		end
	endtask

	task automatic apply_frame(output frame_status_t fs);
		int ch;
		int t;
		logic [63:0] divisor;
		logic [63:0] quot;
		fs = FS_DISCARD;
		ch = int'(chan_q) - 1;
		t = ch >> 1;
		if (mode_q == FM_NONE || nbytes_q != 2'd2 || chan_q < 1 || chan_q > MAX_CH) begin
			fs = FS_DISCARD;
		end else if (mode_q == FM_DUTY) begin
			cmp_pend[ch] = (value_q > period) ? period : value_q;
			fs = FS_DUTY;
		end else if (value_q != '0) begin
			divisor = 64'(period) * 64'(value_q);
			if (divisor == 0) divisor = 64'd1;
			quot = 64'(clock_hz) / divisor;
			if (quot == 0) psc[t] = '0;
			else if (quot - 1 > 64'd65535) psc[t] = 16'hFFFF;
			else psc[t] = 16'(quot - 1);
			psc_cnt[t] = '0;
			per_cnt[t] = '0;
			load_compares(t);
			fs = FS_FREQ;
		end
	endtask

	// one input word in, one expected output word out
	task automatic predict_word(input action_t act, input logic [7:0] rx);
		frame_status_t fs;
		logic [3:0] lv;
		fs = FS_NONE;
		case (act)
			ACT_BYTE: begin
				if ((rx[3:0] == MODE_DUTY_CODE || rx[3:0] == MODE_FREQ_CODE) && mode_q == FM_NONE) begin
					mode_q = (rx[3:0] == MODE_DUTY_CODE) ? FM_DUTY : FM_FREQ;
					chan_q = rx[7:4];
				end else begin
					if (nbytes_q < 2) value_q = value_q | (16'(rx) << (8 * nbytes_q));
					if (nbytes_q < 3) nbytes_q = nbytes_q + 2'd1;
				end
			end
			ACT_STOP: begin
				apply_frame(fs);
				case (fs)
					FS_DUTY: duty_frames++;
					FS_FREQ: freq_frames++;
					default: dropped_frames++;
				endcase
				mode_q = FM_NONE;
				chan_q = '0;
				nbytes_q = '0;
				value_q = '0;
			end
			ACT_TICK: begin
				tick_timer(0);
				tick_timer(1);
			end
			default: ;
		endcase
		for (int c = 0; c < MAX_CH; c++)
			lv[c] = per_cnt[c >> 1] < cmp_act[c];
		expected_words.push_back({2'b00, fs, lv});
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] exp_w;
		if (!arst_n) begin
			clock_hz = CORE_CLOCK_RST;
			period = PERIOD_RST;
			mode_q = FM_NONE;
			chan_q = '0;
			nbytes_q = '0;
			value_q = '0;
			for (int c = 0; c < MAX_CH; c++) begin
				cmp_pend[c] = '0;
				cmp_act[c] = '0;
			end
			for (int t = 0; t < NUM_TIMERS; t++) begin
				psc[t] = '0;
				psc_cnt[t] = '0;
				per_cnt[t] = '0;
			end
			expected_words.delete();
			errors = 0;
			pending = 0;
			checked = 0;
			duty_frames = 0;
			freq_frames = 0;
			dropped_frames = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_PERIOD) period = pwdata[PERIOD_W-1:0];
				else clock_hz = pwdata[CLK_W-1:0];
			end
			// output side
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", -1, m_tdata);
				end else begin
					exp_w = expected_words.pop_front();
					if (m_tdata[3:0] !== exp_w[3:0])
						report_mismatch("pwm_levels", exp_w[3:0], m_tdata[3:0]);
					if (m_tdata[5:4] !== exp_w[5:4])
						report_mismatch("frame_status", exp_w[5:4], m_tdata[5:4]);
					if (m_tdata[7:6] !== 2'b00)
						report_mismatch("padding bits", 0, m_tdata[7:6]);
					checked++;
				end
			end
			// input side
			if (s_tvalid && s_tready) predict_word(action_t'(s_tuser), s_tdata);
			pending = expected_words.size();
		end
	end

endmodule

/* tb/i2c_commanded_quad_pwm_tb.sv */
// Testbench top: stimulus, handshake pacing and verdict for the quad PWM block.
`timescale 1ns / 100ps

module i2c_commanded_quad_pwm_tb;
	import icqp_pkg::*;

	localparam int ITEMS      = 1950;
	localparam int WDOG_LIMIT = 3000;
	localparam int HOLD_LEN   = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
	logic [1:0]  s_tuser = '0;   // [1:0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [3:0] pwm_levels, [5:4] frame_status, [7:6] zero
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int errors, pending, checked, duty_frames, freq_frames, dropped_frames;
	int sent = 0;
	int settings = 1;
	int quiet_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;

	i2c_commanded_quad_pwm u_top (.*);

	icqp_checker u_chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("%0t: timeout, nothing accepted for %0d cycles", $realtime, quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver pacing, with one long hold-off on request
	initial begin
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end else begin
				m_tready <= no_idle || ($urandom_range(0, 99) >= 33);
				@(posedge clk);
			end
		end
	end

	task automatic put_word(input action_t act, input logic [7:0] rx);
		while (!no_idle && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= rx;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic send_frame(input logic [3:0] ch, input logic [3:0] mode_code,
			input logic [15:0] val, input int nbytes);
		put_word(ACT_BYTE, {ch, mode_code});
		for (int i = 0; i < nbytes; i++)
			put_word(ACT_BYTE, (i < 2) ? val[8*i +: 8] : 8'($urandom));
		put_word(ACT_STOP, 8'($urandom));
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// drain every expected word, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic new_setting(input logic [26:0] hz, input logic [15:0] per);
		drain();
		reg_write({REG_CORE_CLOCK, 2'b00}, 32'(hz));
		reg_write({REG_PERIOD, 2'b00}, 32'(per));
		settings++;
	endtask

	task automatic random_block(input int n);
		int stop_at;
		logic [3:0] ch;
		stop_at = sent + n;
		while (sent < stop_at) begin
			if ($urandom_range(0, 9) < 8) begin
				// mostly well formed frames with random content
				ch = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 4)) : 4'($urandom);
				send_frame(ch, $urandom_range(0, 1) ? MODE_DUTY_CODE : MODE_FREQ_CODE,
					($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom),
					($urandom_range(0, 9) < 8) ? 2 : $urandom_range(0, 3));
			end else begin
				put_word(action_t'($urandom_range(0, 3)), 8'($urandom));
			end
			repeat ($urandom_range(0, 30)) put_word(ACT_TICK, 8'($urandom));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ticks, unused action, incomplete frames, clamping, bad channels
		put_word(ACT_TICK, 8'h00);
		put_word(ACT_IDLE, 8'hFF);
		put_word(ACT_BYTE, 8'h00);
		put_word(ACT_STOP, 8'h00);
		put_word(ACT_STOP, 8'hFF);
		send_frame(4'd1, MODE_DUTY_CODE, 16'hFFFF, 2);
		send_frame(4'd3, MODE_DUTY_CODE, 16'h0100, 2);
		send_frame(4'd2, MODE_FREQ_CODE, 16'h0000, 2);
		send_frame(4'd4, MODE_FREQ_CODE, 16'hFFFF, 2);
		send_frame(4'd0, MODE_FREQ_CODE, 16'd10, 2);
		send_frame(4'd15, MODE_DUTY_CODE, 16'd10, 2);
		send_frame(4'd2, MODE_DUTY_CODE, 16'h002A, 1);
		send_frame(4'd2, MODE_DUTY_CODE, 16'h2A5A, 3);
		repeat (4) put_word(ACT_TICK, 8'hFF);

		// long stretch with no idling, then a receiver hold-off
		no_idle = 1'b1;
		random_block(200);
		hold_req = 1'b1;
		random_block(100);
		no_idle = 1'b0;
		random_block(190);

		new_setting(27'd1, 16'd1);
		random_block(480);
		new_setting(27'd100000000, 16'd65535);
		random_block(480);
		new_setting(27'd200, 16'd6);
		random_block(480);

		drain();
		$display("Sent %0d words over %0d register settings; %0d results checked",
			sent, settings, checked);
		$display("Frames applied: %0d duty, %0d frequency; %0d discarded",
			duty_frames, freq_frames, dropped_frames);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/icqp_pkg.sv
rtl/core/icqp_div.sv
rtl/core/icqp_ctrl.sv
rtl/core/icqp_dp.sv
rtl/core/i2c_commanded_quad_pwm.sv
tb/icqp_checker.sv
tb/i2c_commanded_quad_pwm_tb.sv
